// ----- hw/rtl/dtdiff_pkg.sv -----
// Shared types, constants and the month length table for the date difference block.
`timescale 1ns / 1ps
`default_nettype none

package dtdiff_pkg;

  localparam int DATE_W    = 27;
  localparam int YEAR_W    = 14;
  localparam int MD_W      = 7;
  localparam int DOY_W     = 13;
  localparam int ELAP_W    = 22;
  localparam int THR_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int DIFF_W    = 24;
  localparam int PROD_W    = 2 * DATE_W;
  localparam int QMUL_W    = 2 * YEAR_W;

  localparam logic [DATE_W-1:0] DATE_MOD = 27'd100000000;

  // Reciprocal constants: for x below 10^8, x / 10000 = (x * RECIP_10K) >> 40, and
  // for x below 10^4, x / 100 = (x * RECIP_100) >> 20, both exactly.
  localparam logic [DATE_W-1:0] TEN_K        = 27'd10000;
  localparam logic [DATE_W-1:0] RECIP_10K    = 27'd109951163;
  localparam int                RECIP_10K_SH = 40;
  localparam logic [YEAR_W-1:0] HUNDRED      = 14'd100;
  localparam logic [YEAR_W-1:0] RECIP_100    = 14'd10486;
  localparam int                RECIP_100_SH = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_START_DATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERDUE_THR = 2'd1;

  localparam logic [DATE_W-1:0] START_RESET = '0;
  localparam logic [THR_W-1:0]  THR_RESET   = 16'd7;

  localparam logic [ELAP_W-1:0] COMMON_YEAR_DAYS = 22'd365;

  typedef struct packed {
    logic load_cur;
    logic load_start;
    logic calc_year;
    logic calc_rem;
    logic calc_mon;
    logic calc_day;
    logic mon_init;
    logic mon_step;
    logic save_cur;
    logic fin_mul;
    logic fin_sum;
  } dp_cmd_t;

  typedef struct packed {
    logic mon_last;
  } dp_sts_t;

  // Length of month m; anything outside the calendar counts 30 days.
  function automatic logic [4:0] month_len(input logic [MD_W-1:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
      7'd2:    len = leap ? 5'd29 : 5'd28;
      default: len = 5'd30;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dtdiff_div.sv -----
// Date split by constant divisors using reciprocal multiplication, one step per cycle.
`timescale 1ns / 1ps
`default_nettype none

module dtdiff_div
  import dtdiff_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              calc_year,
  input  wire logic              calc_rem,
  input  wire logic              calc_mon,
  input  wire logic              calc_day,
  input  wire logic [DATE_W-1:0] date,
  output logic [YEAR_W-1:0]      year,
  output logic [MD_W-1:0]        mon,
  output logic [MD_W-1:0]        day,
  output logic [MD_W-1:0]        q100,
  output logic                   z100
);

  logic [YEAR_W-1:0] year_r;
  logic [YEAR_W-1:0] rem10k_r;
  logic [MD_W-1:0]   mon_r;
  logic [MD_W-1:0]   day_r;
  logic [MD_W-1:0]   q100_r;
  logic              z100_r;

  logic [PROD_W-1:0] year_prod;
  logic [DATE_W-1:0] year_scaled;
  logic [DATE_W-1:0] rem10k_full;
  logic [QMUL_W-1:0] q100_prod;
  logic [QMUL_W-1:0] mon_prod;
  logic [YEAR_W-1:0] cent_scaled;
  logic [YEAR_W-1:0] mon_scaled;
  logic [YEAR_W-1:0] day_full;

  assign year_prod   = PROD_W'(date) * PROD_W'(RECIP_10K);
  assign year_scaled = DATE_W'(year_r) * TEN_K;
  assign rem10k_full = date - year_scaled;
  assign q100_prod   = QMUL_W'(year_r) * QMUL_W'(RECIP_100);
  assign mon_prod    = QMUL_W'(rem10k_r) * QMUL_W'(RECIP_100);
  assign cent_scaled = YEAR_W'(q100_r) * HUNDRED;
  assign mon_scaled  = YEAR_W'(mon_r) * HUNDRED;
  assign day_full    = rem10k_r - mon_scaled;

  // Year first, then the low four digits and the century count, then the month and
  // the century remainder test, then the day.
  always_ff @(posedge clk) begin
    if (calc_year) begin
      year_r <= year_prod[RECIP_10K_SH +: YEAR_W];
    end
    if (calc_rem) begin
      rem10k_r <= rem10k_full[YEAR_W-1:0];
      q100_r   <= q100_prod[RECIP_100_SH +: MD_W];
    end
    if (calc_mon) begin
      mon_r  <= mon_prod[RECIP_100_SH +: MD_W];
      z100_r <= (year_r == cent_scaled);
    end
    if (calc_day) begin
      day_r <= day_full[MD_W-1:0];
    end
  end

  assign year = year_r;
  assign mon  = mon_r;
  assign day  = day_r;
  assign q100 = q100_r;
  assign z100 = z100_r;

endmodule

`default_nettype wire

// ----- hw/rtl/dtdiff_dp.sv -----
// Datapath: configuration registers, date split, day-of-year walk and final difference.
`timescale 1ns / 1ps
`default_nettype none

module dtdiff_dp
  import dtdiff_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dp_cmd_t              cmd,
  output dp_sts_t                   sts,
  input  wire logic [DATE_W-1:0]    in_current_date,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATE_W-1:0]    cfg_data,
  output logic                      out_valid,
  output logic [ELAP_W-1:0]         out_elapsed_days,
  output logic                      out_overdue,
  output logic                      out_order_error
);

  logic [DATE_W-1:0] start_date_r;
  logic [THR_W-1:0]  thr_r;

  logic [DATE_W-1:0] work_r;
  logic [MD_W-1:0]   mcnt_r;
  logic [DOY_W-1:0]  acc_r;
  logic [DOY_W-1:0]  pa_r;
  logic [YEAR_W-1:0] ya_r;
  logic [ELAP_W-1:0] prod_r;
  logic [DOY_W:0]    pdiff_r;
  logic              erry_r;

  logic              valid_r;
  logic [ELAP_W-1:0] elapsed_r;
  logic              overdue_r;
  logic              err_r;

  logic [YEAR_W-1:0] year;
  logic [MD_W-1:0]   mon;
  logic [MD_W-1:0]   day;
  logic [MD_W-1:0]   q100;
  logic              z100;
  logic              z400;

  logic [DATE_W-1:0] load_src;
  logic [DATE_W-1:0] load_red;
  logic              leap;
  logic [DOY_W-1:0]  leaps_below;
  logic [YEAR_W-1:0] ydiff;
  logic [DIFF_W-1:0] diff_sum;
  logic              err_all;
  logic [ELAP_W-1:0] elapsed_val;

  // Only the low eight decimal digits count; a 27-bit value is below twice the modulus.
  assign load_src = cmd.load_start ? start_date_r : in_current_date;
  assign load_red = (load_src >= DATE_MOD) ? (load_src - DATE_MOD) : load_src;

  dtdiff_div u_div (
    .clk       (clk),
    .calc_year (cmd.calc_year),
    .calc_rem  (cmd.calc_rem),
    .calc_mon  (cmd.calc_mon),
    .calc_day  (cmd.calc_day),
    .date      (work_r),
    .year      (year),
    .mon       (mon),
    .day       (day),
    .q100      (q100),
    .z100      (z100)
  );

  // A year divides by 400 when it divides by 100 and its century count by 4.
  assign z400 = z100 & (q100[1:0] == 2'b00);
  assign leap = z400 | ((year[1:0] == 2'b00) & ~z100);

  // ceil(y/4) - ceil(y/100) + ceil(y/400): leap years below y.
  assign leaps_below = DOY_W'(year[YEAR_W-1:2])
                     + {{(DOY_W-1){1'b0}}, (year[1:0] != 2'b00)}
                     - DOY_W'(q100) - {{(DOY_W-1){1'b0}}, ~z100}
                     + DOY_W'(q100[MD_W-1:2]) + {{(DOY_W-1){1'b0}}, ~z400};

  assign ydiff    = ya_r - year;
  assign diff_sum = DIFF_W'(prod_r) + {{(DIFF_W-DOY_W-1){pdiff_r[DOY_W]}}, pdiff_r};
  assign err_all  = erry_r | diff_sum[DIFF_W-1];
  assign elapsed_val = err_all ? '0 : diff_sum[ELAP_W-1:0];

  assign sts.mon_last = (mcnt_r >= mon);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_date_r <= START_RESET;
      thr_r        <= THR_RESET;
      valid_r      <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == CFG_START_DATE)) begin
        start_date_r <= cfg_data;
      end
      if (cfg_we && (cfg_index == CFG_OVERDUE_THR)) begin
        thr_r <= cfg_data[THR_W-1:0];
      end
      valid_r <= cmd.fin_sum;
    end

    if (cmd.load_cur || cmd.load_start) begin
      work_r <= load_red;
    end
    if (cmd.mon_init) begin
      acc_r  <= leaps_below + DOY_W'(day);
      mcnt_r <= MD_W'(1);
    end else if (cmd.mon_step) begin
      acc_r  <= acc_r + DOY_W'(month_len(mcnt_r, leap));
      mcnt_r <= mcnt_r + 1'b1;
    end
    if (cmd.save_cur) begin
      pa_r <= acc_r;
      ya_r <= year;
    end
    if (cmd.fin_mul) begin
      erry_r  <= (ya_r < year);
      prod_r  <= ELAP_W'(ydiff) * COMMON_YEAR_DAYS;
      pdiff_r <= {1'b0, pa_r} - {1'b0, acc_r};
    end
    if (cmd.fin_sum) begin
      elapsed_r <= elapsed_val;
      overdue_r <= (elapsed_val >= ELAP_W'(thr_r));
      err_r     <= err_all;
    end
  end

  assign out_valid        = valid_r;
  assign out_elapsed_days = elapsed_r;
  assign out_overdue      = overdue_r;
  assign out_order_error  = err_r;

endmodule

`default_nettype wire

// ----- hw/rtl/dtdiff_ctrl.sv -----
// Controller state machine that sequences date splits, month walks and the final sum.
`timescale 1ns / 1ps
`default_nettype none

module dtdiff_ctrl
  import dtdiff_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd,
  output logic         busy
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_YEAR,
    S_REM,
    S_MON,
    S_DAY,
    S_MINIT,
    S_MSTEP,
    S_FIN_MUL,
    S_FIN_SUM
  } state_t;

  state_t state_r, state_nxt;
  logic   side_r, side_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    side_nxt  = side_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_cur = 1'b1;
          side_nxt     = 1'b0;
          state_nxt    = S_YEAR;
        end
      end
      S_YEAR: begin
        cmd.calc_year = 1'b1;
        state_nxt     = S_REM;
      end
      S_REM: begin
        cmd.calc_rem = 1'b1;
        state_nxt    = S_MON;
      end
      S_MON: begin
        cmd.calc_mon = 1'b1;
        state_nxt    = S_DAY;
      end
      S_DAY: begin
        cmd.calc_day = 1'b1;
        state_nxt    = S_MINIT;
      end
      S_MINIT: begin
        cmd.mon_init = 1'b1;
        state_nxt    = S_MSTEP;
      end
      S_MSTEP: begin
        if (!sts.mon_last) begin
          cmd.mon_step = 1'b1;
        end else if (!side_r) begin
          cmd.save_cur   = 1'b1;
          cmd.load_start = 1'b1;
          side_nxt       = 1'b1;
          state_nxt      = S_YEAR;
        end else begin
          state_nxt = S_FIN_MUL;
        end
      end
      S_FIN_MUL: begin
        cmd.fin_mul = 1'b1;
        state_nxt   = S_FIN_SUM;
      end
      S_FIN_SUM: begin
        cmd.fin_sum = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      side_r  <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      side_r  <= side_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

`default_nettype wire

// ----- hw/rtl/date_difference_in_days_top.sv -----
// Top level of the date difference block: controller, datapath and configuration port.
// Each item splits and walks the current date, then the start date, then runs the
// final multiply and sum; ka and kb are the months walked for the current and start
// dates (month - 1, or 0). Each date takes four split steps, one seed step and one walk
// step per month plus one. A new start can first be taken in the strobe cycle; the
// receiver cannot stall. Synchronous reset idles, sets start 0, threshold 7.
`timescale 1ns / 1ps
`default_nettype none

module date_difference_in_days_top
  import dtdiff_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  // Command channel: an item transfers at an edge with start high and busy low.
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [DATE_W-1:0]    in_current_date,

  // Result channel: one strobe cycle per item.
  output logic                      out_valid,
  output logic [ELAP_W-1:0]         out_elapsed_days,
  output logic                      out_overdue,
  output logic                      out_order_error,

  // Configuration write channel.
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATE_W-1:0]    cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Configuration writes are to be issued only while the block is idle; the block
  // itself does not enforce this, and the port can accept a transfer in every cycle.
  assign cfg_ready = 1'b1;

  // The controller steps through the split of each date into year, month and
  // day, the leap year counts, and the month walk, then the final sum.
  dtdiff_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The datapath holds the configuration registers, the date split unit and the
  // output registers; the result stays in its registers until the next item.
  dtdiff_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_current_date  (in_current_date),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_elapsed_days (out_elapsed_days),
    .out_overdue      (out_overdue),
    .out_order_error  (out_order_error)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/dtdiff_chk.sv -----
// Port-level checker for the date difference block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dtdiff_chk
  import dtdiff_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire logic [ELAP_W-1:0] out_elapsed_days,
  input wire logic              out_order_error
);

  // A transfer on the command channel makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after a command transfer");

  // The result appears as the block goes idle, never while it is still working.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("busy fell without a result");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_order_error) |-> (out_elapsed_days == '0))
    else $error("nonzero elapsed days on order error");

endmodule

bind date_difference_in_days_top dtdiff_chk u_dtdiff_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_elapsed_days (out_elapsed_days),
  .out_order_error  (out_order_error)
);

`default_nettype wire
